### design/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the fixed-point matrix-vector multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mvm_pkg;

    // Field widths
    localparam int ELEM_FIELDS = 8;    // element ports on the input channel
    localparam int ELEM_W      = 16;   // signed Q8.8 element
    localparam int PROD_W      = 32;   // signed Q16.16 product
    localparam int ACC_W       = 48;   // accumulator
    localparam int Y_W         = 32;   // saturated result
    localparam int RLEN_W      = 11;   // row_length register
    localparam int ROWS_W      = 16;   // row_count register and row counter
    localparam int DATA_W      = 32;   // config bus data
    localparam int ADDR_W      = 3;    // config bus address

    // Saturation limits
    localparam logic [Y_W-1:0] Y_MAX = 32'h7FFF_FFFF;
    localparam logic [Y_W-1:0] Y_MIN = 32'h8000_0000;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_ROW  = 1'b1;

    // Config register index (byte address bit 2)
    typedef enum logic [0:0] {
        REG_ROW_LENGTH = 1'b0,
        REG_ROW_COUNT  = 1'b1
    } reg_idx_t;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Control that travels with a row item down the pipeline
    typedef struct packed {
        logic valid;     // a row item occupies this stage
        logic row_end;   // this item completes the row
        logic last;      // completed row is the last of the matrix
    } ctl_t;

endpackage

`default_nettype wire

### design/matrix_vector_multiply.sv
// Pipeline: a row item completing a row passes the vector read, lane multiply,
//   lane sum and accumulate registers before its result shows.
// Throughput: one item per cycle unless out_stall holds back a result; the
//   vector store has one bank per lane so one read of every bank serves an item.
// Reset: positions, accumulator, row counter and pipeline valids clear;
//   row_length resets to 8, row_count to 1; the vector store is not cleared.
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Fixed-point y = A*x engine: parallel Q8.8 multiply lanes feeding a summing
// stage and a 48-bit accumulator, with an APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_vector_multiply #(
    parameter int MAX_LEN = 1024,
    parameter int LANES   = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               func,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]  elem0,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]  elem1,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]  elem2,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]  elem3,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]  elem4,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]  elem5,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]  elem6,
    input  wire logic signed [mvm_pkg::ELEM_W-1:0]  elem7,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [mvm_pkg::Y_W-1:0]          y_value,
    output logic                                    saturated,
    output logic                                    last_row,
    // register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mvm_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [mvm_pkg::DATA_W-1:0]         pwdata,
    output logic [mvm_pkg::DATA_W-1:0]              prdata,
    output logic                                    pready
);

    import mvm_pkg::*;

    localparam int NL    = (LANES < ELEM_FIELDS) ? LANES : ELEM_FIELDS;
    localparam int DEPTH = (MAX_LEN + NL - 1) / NL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(MAX_LEN + 1);
    localparam int SW    = PW + 4;

    // ---------------- register port ----------------
    logic [RLEN_W-1:0] row_length_reg;
    logic [ROWS_W-1:0] row_count_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= RLEN_W'(8);
            row_count_reg  <= ROWS_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ROW_LENGTH: row_length_reg <= pwdata[RLEN_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= pwdata[ROWS_W-1:0];
                default:        row_length_reg <= row_length_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ROW_LENGTH: prdata = DATA_W'(row_length_reg);
            REG_ROW_COUNT:  prdata = DATA_W'(row_count_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic adv;
    logic accept;

    // whole pipeline moves unless a finished result is held back
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // ---------------- item position tracking ----------------
    logic [PW-1:0]     load_pos_reg;
    logic [PW-1:0]     load_pos_next;
    logic [AW-1:0]     load_word_reg;
    logic [AW-1:0]     load_word_next;
    logic [PW-1:0]     row_pos_reg;
    logic [PW-1:0]     row_pos_next;
    logic [AW-1:0]     row_word_reg;
    logic [AW-1:0]     row_word_next;
    logic [ROWS_W-1:0] row_cnt_reg;
    logic [ROWS_W-1:0] row_cnt_next;

    logic [PW-1:0]     eff_len;
    logic [PW-1:0]     pos_sel;
    logic [SW-1:0]     pos_adv;
    logic              item_end;
    logic [NL-1:0]     lane_mask;
    logic [ROWS_W-1:0] rows;
    logic              is_last;
    ctl_t              ctl1_next;

    always_comb
    begin
        // effective length: zero acts as one, capped at the store size
        if (row_length_reg == '0)
        begin
            eff_len = PW'(1);
        end
        else if (32'(row_length_reg) > MAX_LEN)
        begin
            eff_len = PW'(MAX_LEN);
        end
        else
        begin
            eff_len = PW'(row_length_reg);
        end

        pos_sel  = (func == FUNC_ROW) ? row_pos_reg : load_pos_reg;
        pos_adv  = SW'(pos_sel) + SW'(NL);
        item_end = pos_adv >= SW'(eff_len);

        for (int l = 0; l < NL; l++)
        begin
            lane_mask[l] = (SW'(pos_sel) + SW'(l)) < SW'(eff_len);
        end

        rows    = (row_count_reg == '0) ? ROWS_W'(1) : row_count_reg;
        is_last = ({1'b0, row_cnt_reg} + 17'd1) >= {1'b0, rows};

        load_pos_next  = load_pos_reg;
        load_word_next = load_word_reg;
        row_pos_next   = row_pos_reg;
        row_word_next  = row_word_reg;
        row_cnt_next   = row_cnt_reg;
        ctl1_next      = '0;

        if (accept)
        begin
            if (func == FUNC_ROW)
            begin
                row_pos_next    = item_end ? '0 : pos_adv[PW-1:0];
                row_word_next   = item_end ? '0 : row_word_reg + AW'(1);
                ctl1_next.valid = 1'b1;
                ctl1_next.row_end = item_end;
                ctl1_next.last  = item_end && is_last;
                if (item_end)
                begin
                    row_cnt_next = is_last ? '0 : row_cnt_reg + ROWS_W'(1);
                end
            end
            else
            begin
                load_pos_next  = item_end ? '0 : pos_adv[PW-1:0];
                load_word_next = item_end ? '0 : load_word_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg  <= '0;
            load_word_reg <= '0;
            row_pos_reg   <= '0;
            row_word_reg  <= '0;
            row_cnt_reg   <= '0;
        end
        else
        begin
            load_pos_reg  <= load_pos_next;
            load_word_reg <= load_word_next;
            row_pos_reg   <= row_pos_next;
            row_word_reg  <= row_word_next;
            row_cnt_reg   <= row_cnt_next;
        end
    end

    // ---------------- stage 1: vector read, element capture ----------------
    logic [ELEM_FIELDS-1:0][ELEM_W-1:0] elem_all;
    logic [NL-1:0][ELEM_W-1:0]          elem1_reg;
    logic [NL-1:0]                      mask1_reg;
    ctl_t                               ctl1_reg;
    ctl_t                               ctl2_reg;
    logic [NL-1:0][ELEM_W-1:0]          xval;
    logic [NL-1:0][PROD_W-1:0]          prod;

    assign elem_all = {elem7, elem6, elem5, elem4, elem3, elem2, elem1, elem0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            elem1_reg <= elem_all[NL-1:0];
            mask1_reg <= lane_mask;
        end
    end

    // ---------------- banks and lanes ----------------
    // element p of the vector lives in bank p mod NL, word p / NL
    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        mvm_ram #(
            .WIDTH (ELEM_W),
            .DEPTH (DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (accept && (func == FUNC_LOAD) && lane_mask[l]),
            .waddr (load_word_reg),
            .wdata (elem_all[l]),
            .re    (adv),
            .raddr (row_word_reg),
            .rdata (xval[l])
        );

        mvm_lane u_lane (
            .clk  (clk),
            .adv  (adv),
            .mask (mask1_reg[l]),
            .elem (elem_t'(elem1_reg[l])),
            .xval (elem_t'(xval[l])),
            .prod (prod[l])
        );
    end

    // ---------------- merge, accumulate, result ----------------
    mvm_merge #(
        .NL (NL)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl       (ctl2_reg),
        .prod      (prod),
        .out_valid (out_valid),
        .y_value   (y_value),
        .saturated (saturated),
        .last_row  (last_row)
    );

endmodule

`default_nettype wire

### design/mvm_ram.sv
// ----------------------------------------------------------------------------
// mvm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/mvm_lane.sv
// ----------------------------------------------------------------------------
// mvm_lane
// One multiply lane: Q8.8 row element times Q8.8 vector element, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_lane (
    input  wire logic          clk,
    input  wire logic          adv,
    input  wire logic          mask,
    input  wire mvm_pkg::elem_t elem,
    input  wire mvm_pkg::elem_t xval,
    output mvm_pkg::prod_t     prod
);

    import mvm_pkg::*;

    prod_t prod_reg;
    prod_t prod_next;

    // Lanes past the row end contribute zero; operands widen before the multiply
    always_comb
    begin
        prod_next = mask ? (prod_t'(elem) * prod_t'(xval)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### design/mvm_merge.sv
// ----------------------------------------------------------------------------
// mvm_merge
// Horizontal sum of the lane products, 48-bit row accumulator, saturation
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_merge #(
    parameter int NL = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            adv,
    input  wire mvm_pkg::ctl_t                   ctl,
    input  wire logic [NL-1:0][mvm_pkg::PROD_W-1:0] prod,
    output logic                                 out_valid,
    output logic signed [mvm_pkg::Y_W-1:0]       y_value,
    output logic                                 saturated,
    output logic                                 last_row
);

    import mvm_pkg::*;

    localparam int SUM_W = PROD_W + $clog2(NL) + 1;

    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    ctl_t                    ctl_reg;

    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [ACC_W-1:0]        acc_sum;
    logic                    in_range;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [Y_W-1:0]          y_reg;
    logic [Y_W-1:0]          y_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic                    last_reg;
    logic                    last_next;

    // Adder tree over the lanes
    always_comb
    begin
        sum_next = '0;
        for (int l = 0; l < NL; l++)
        begin
            sum_next = sum_next + SUM_W'($signed(prod[l]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= sum_next;
        end
    end

    // Accumulate, saturate at row end
    always_comb
    begin
        acc_sum  = acc_reg + ACC_W'(sum_reg);
        in_range = (acc_sum[ACC_W-1:Y_W-1] == '0) || (acc_sum[ACC_W-1:Y_W-1] == '1);

        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        y_next         = y_reg;
        sat_next       = sat_reg;
        last_next      = last_reg;

        if (adv)
        begin
            out_valid_next = ctl_reg.valid && ctl_reg.row_end;
            if (ctl_reg.valid)
            begin
                acc_next = ctl_reg.row_end ? '0 : acc_sum;
            end
            if (ctl_reg.valid && ctl_reg.row_end)
            begin
                sat_next  = !in_range;
                last_next = ctl_reg.last;
                if (in_range)
                begin
                    y_next = acc_sum[Y_W-1:0];
                end
                else
                begin
                    y_next = acc_sum[ACC_W-1] ? Y_MIN : Y_MAX;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        sat_reg  <= sat_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign y_value   = y_reg;
    assign saturated = sat_reg;
    assign last_row  = last_reg;

endmodule

`default_nettype wire
